// ===== design/assert_macros.svh =====
// assertion helpers for the design folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== design/sha_pkg.sv =====
`timescale 1ns / 1ps
package sha_pkg;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } cmd_t;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

// ===== design/sha_in_if.sv =====
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink (input valid, data_byte, has_byte, last, output ready);
endinterface

// ===== design/sha_out_if.sv =====
`timescale 1ns / 1ps
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// the first digest word follows the closing transfer via the queue, the pad fill up to the length
// slot, the length write, and the rounds plus add, twice when a second block is due;
// then 8 words at one per cycle while out_ch.ready stays high
// one byte per cycle into the block while the core is idle; each full block then runs its rounds
// and add while the front queue keeps taking transfers, holding up to 4 bytes or closes meanwhile
// reset: rst_n asynchronous active low, hash words return to the initial values, block empty
module sha256_byte_stream_hasher #(
    parameter int QueueDepth = sha_pkg::QueueDepth
) (
    input  logic       clk,
    input  logic       rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);
    // queue between front and back
    logic          q_valid;
    logic          q_ready;
    sha_pkg::cmd_t q_cmd;

    // front: accepts transfers while not full, keeps only bytes and closes
    sha_queue #(.Depth(QueueDepth)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    // back: block fill, padding, 64-round compression and digest output
    sha_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd),
        .out_ch  (out_ch)
    );
endmodule

// ===== design/sha_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha_queue #(
    parameter int Depth = sha_pkg::QueueDepth
) (
    input  logic          clk,
    input  logic          rst_n,
    sha_in_if.sink        in_ch,
    output logic          q_valid,
    input  logic          q_ready,
    output sha_pkg::cmd_t q_cmd
);
    localparam int AW = $clog2(Depth);
    sha_pkg::cmd_t    mem_reg [Depth];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push, pop;

    assign in_ch.ready = (count_reg < (AW+1)'(Depth));
    // drop items that carry neither byte nor close
    assign push = in_ch.valid && in_ch.ready && (in_ch.has_byte || in_ch.last);
    assign q_valid = (count_reg != '0);
    assign pop = q_valid && q_ready;
    assign q_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{in_ch.data_byte, in_ch.has_byte, in_ch.last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, count_reg < (AW+1)'(Depth))
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, count_reg != '0)
    `ASSERT_NEXT(a_count_step, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)
endmodule

// ===== design/sha_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sha_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    output logic          q_ready,
    input  sha_pkg::cmd_t q_cmd,
    sha_out_if.source     out_ch
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LEN   = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];      // block words, then the rolling schedule
    logic [5:0]   t_reg;
    logic         closing_reg;     // message closed, pad pass under way
    logic         final_reg;       // block in flight carries the length
    logic         pad_first_reg;   // next pad byte is the 0x80 marker
    logic [2:0]   out_idx_reg;
    logic         out_valid_reg;

    logic [31:0] w_now, s1, s0, ch, maj, t1, t2, g0, g1;
    logic [31:0] a2, a15;
    logic [3:0]  word_sel;
    logic [4:0]  byte_sel;
    logic        take;

    // byte n of the block sits big-endian in word n/4
    assign word_sel = fill_reg[5:2];
    assign byte_sel = {~fill_reg[1:0], 3'b000};

    assign a2  = w_reg[4'(t_reg - 6'd2)];
    assign a15 = w_reg[4'(t_reg - 6'd15)];
    assign g1 = sha_pkg::rotr(a2, 17) ^ sha_pkg::rotr(a2, 19) ^ (a2 >> 10);
    assign g0 = sha_pkg::rotr(a15, 7) ^ sha_pkg::rotr(a15, 18) ^ (a15 >> 3);

    always_comb
    begin
        if (t_reg < 6'd16)
        begin
            w_now = w_reg[t_reg[3:0]];
        end
        else
        begin
            w_now = g1 + w_reg[4'(t_reg - 6'd7)] + g0 + w_reg[t_reg[3:0]];
        end
    end

    assign s1  = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
               ^ sha_pkg::rotr(v_reg[4], 25);
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1  = v_reg[7] + s1 + ch + sha_pkg::RoundK[t_reg] + w_now;
    assign s0  = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
               ^ sha_pkg::rotr(v_reg[0], 22);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2  = s0 + maj;

    assign q_ready = (state_reg == S_IDLE);
    assign take    = q_valid && q_ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.digest_word = h_reg[out_idx_reg];
    assign out_ch.word_index  = out_idx_reg;
    assign out_ch.last_word   = (out_idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take && q_cmd.has_byte && fill_reg == 6'd63)
                begin
                    state_next = S_ROUND;
                end
                else if (take && q_cmd.last)
                begin
                    state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                // one pad byte per cycle until the block end or the length slot
                if (fill_reg == 6'd63)
                begin
                    state_next = S_ROUND;
                end
                else if (fill_reg == 6'd55)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:    state_next = S_ROUND;
            S_ROUND:  state_next = (t_reg == 6'd63) ? S_ADD : S_ROUND;
            S_ADD:
            begin
                if (final_reg)
                begin
                    state_next = S_OUT;
                end
                else if (closing_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                if (out_ch.ready && out_idx_reg == 3'd7)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (take && q_cmd.has_byte)
                begin
                    w_reg[word_sel][byte_sel +: 8] <= q_cmd.data_byte;
                end
            end
            S_PAD:
            begin
                w_reg[word_sel][byte_sel +: 8] <= pad_first_reg ? sha_pkg::PadByte : 8'h00;
            end
            S_LEN:
            begin
                w_reg[14] <= bits_reg[63:32];
                w_reg[15] <= bits_reg[31:0];
            end
            S_ROUND:
            begin
                w_reg[t_reg[3:0]] <= w_now;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            t_reg         <= '0;
            closing_reg   <= 1'b0;
            final_reg     <= 1'b0;
            pad_first_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::InitHash[i];
                v_reg[i] <= sha_pkg::InitHash[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        if (q_cmd.has_byte)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                            bits_reg <= bits_reg + 64'd8;
                        end
                        if (q_cmd.last)
                        begin
                            closing_reg   <= 1'b1;
                            pad_first_reg <= 1'b1;
                        end
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                    t_reg <= '0;
                end
                S_PAD:
                begin
                    pad_first_reg <= 1'b0;
                    // wraps to zero when the block is full
                    fill_reg <= fill_reg + 1'b1;
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                    t_reg <= '0;
                end
                S_LEN:
                begin
                    final_reg <= 1'b1;
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                    t_reg <= '0;
                end
                S_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    t_reg <= t_reg + 1'b1;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (final_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= '0;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        out_idx_reg <= out_idx_reg + 1'b1;
                        if (out_idx_reg == 3'd7)
                        begin
                            out_valid_reg <= 1'b0;
                            closing_reg   <= 1'b0;
                            final_reg     <= 1'b0;
                            pad_first_reg <= 1'b0;
                            bits_reg      <= '0;
                            fill_reg      <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha_pkg::InitHash[i];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPLIES(a_out_only_in_out, clk, rst_n, out_valid_reg, state_reg == S_OUT)
    `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, q_ready, !out_valid_reg)
    `ASSERT_NEXT(a_round_step, clk, rst_n, state_reg == S_ROUND && t_reg != 6'd63,
                 state_reg == S_ROUND)
endmodule

// ===== tb/sv/sha256_digest_checker.sv =====
`timescale 1ns / 1ps
module sha256_digest_checker (
    input  logic clk,
    input  logic rst_n,
    sha_in_if    in_ch,
    sha_out_if   out_ch,
    output int   fail_count,
    output int   words_pending
);
    typedef struct {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_word_t;

    localparam logic [31:0] IvWords [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundConst [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic [31:0]  chain_words [8];
    logic [7:0]   msg_block [64];
    int           fill_bytes;
    logic [63:0]  msg_bit_len;
    digest_word_t digest_queue [$];

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        for (int i = 0; i < 8; i++)
            v[i] = chain_words[i];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain_words[i] = chain_words[i] + v[i];
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            chain_words[i] = IvWords[i];
        fill_bytes  = 0;
        msg_bit_len = '0;
    endtask

    task automatic absorb_transfer(input logic [7:0] b, input logic hb, input logic lst);
        digest_word_t dw;
        if (hb)
        begin
            msg_block[fill_bytes] = b;
            fill_bytes++;
            msg_bit_len += 64'd8;
            if (fill_bytes == 64)
            begin
                compress_msg_block();
                fill_bytes = 0;
            end
        end
        if (lst)
        begin
            msg_block[fill_bytes] = 8'h80;
            fill_bytes++;
            if (fill_bytes > 56)
            begin
                while (fill_bytes < 64)
                    msg_block[fill_bytes++] = 8'h00;
                compress_msg_block();
                fill_bytes = 0;
            end
            while (fill_bytes < 56)
                msg_block[fill_bytes++] = 8'h00;
            for (int i = 0; i < 8; i++)
                msg_block[63-i] = msg_bit_len[8*i +: 8];
            compress_msg_block();
            for (int i = 0; i < 8; i++)
            begin
                dw.digest_word = chain_words[i];
                dw.word_index  = 3'(i);
                dw.last_word   = (i == 7);
                digest_queue.push_back(dw);
            end
            restart_message();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            restart_message();
            digest_queue.delete();
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                absorb_transfer(in_ch.data_byte, in_ch.has_byte, in_ch.last);
            if (out_ch.valid && out_ch.ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %h/%0d/%0d", $time,
                             out_ch.digest_word, out_ch.word_index, out_ch.last_word);
                    fail_count++;
                end
                else
                begin
                    digest_word_t exp_w;
                    exp_w = digest_queue.pop_front();
                    if (out_ch.digest_word !== exp_w.digest_word)
                    begin
                        $display("%0t: digest_word mismatch: expected %h, actual %h", $time,
                                 exp_w.digest_word, out_ch.digest_word);
                        fail_count++;
                    end
                    if (out_ch.word_index !== exp_w.word_index)
                    begin
                        $display("%0t: word_index mismatch: expected %0d, actual %0d", $time,
                                 exp_w.word_index, out_ch.word_index);
                        fail_count++;
                    end
                    if (out_ch.last_word !== exp_w.last_word)
                    begin
                        $display("%0t: last_word mismatch: expected %0d, actual %0d", $time,
                                 exp_w.last_word, out_ch.last_word);
                        fail_count++;
                    end
                end
            end
        end
        words_pending = digest_queue.size();
    end
endmodule

// ===== tb/sv/tb_sha256_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
module tb_sha256_byte_stream_hasher;
    logic clk;
    logic rst_n;
    int   fail_count;
    int   words_pending;
    int   items_sent;
    int   cycle_count;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_byte_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    sha256_digest_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // offer one item and hold it until the transfer happens
    task automatic offer_item(input logic [7:0] b, input logic hb, input logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.has_byte  <= hb;
        in_ch.last      <= lst;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // one message of len bytes, closed either on the final byte or by a bare last item
    task automatic send_message(input int len, input bit with_noise);
        bit bare_close;
        bare_close = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            if (with_noise && $urandom_range(0, 9) == 0)
                offer_item(8'($urandom), 1'b0, 1'b0);
            offer_item(8'($urandom), 1'b1, !bare_close && (i == len - 1));
        end
        if (bare_close)
            offer_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // receiver: random ready stretches, plus one long hold-off so the input backs up
    initial
    begin
        int stretch;
        bit held_off;
        held_off = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && cycle_count > 800)
            begin
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else
            begin
                stretch = $urandom_range(1, 20);
                if ($urandom_range(0, 2) == 0)
                    out_ch.ready <= 1'b1;
                else
                    out_ch.ready <= ($urandom_range(0, 1) == 1);
                repeat (stretch) @(posedge clk);
            end
        end
    end

    // overall watchdog
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int len;
        int r;
        items_sent      = 0;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.has_byte  <= 1'b0;
        in_ch.last      <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, idle items, extreme bytes, bare close after bytes
        offer_item(8'hff, 1'b0, 1'b1);
        offer_item(8'hff, 1'b0, 1'b0);
        offer_item(8'h00, 1'b0, 1'b0);
        offer_item(8'h00, 1'b1, 1'b1);
        offer_item(8'hff, 1'b1, 1'b1);
        offer_item(8'h61, 1'b1, 1'b0);
        offer_item(8'h62, 1'b1, 1'b0);
        offer_item(8'h63, 1'b1, 1'b0);
        offer_item(8'h55, 1'b0, 1'b1);
        offer_item(8'haa, 1'b1, 1'b0);
        offer_item(8'h00, 1'b0, 1'b0);
        offer_item(8'h7f, 1'b1, 1'b1);
        offer_item(8'h00, 1'b0, 1'b1);

        // random: padding boundaries weighted, short messages otherwise
        while (items_sent < 320)
        begin
            r = $urandom_range(0, 9);
            case (r)
                0: len = 55;
                1: len = 56;
                2: len = $urandom_range(57, 65);
                3: len = 0;
                default: len = $urandom_range(1, 20);
            endcase
            send_message(len, 1'b1);
        end
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (fail_count == 0 && words_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
